// ===== design/gdr_pkg.sv =====
// shared constants, types and sine table of the grid dda ray caster
package gdr_pkg;

  // map, walk and angle sizing (MAP_DIM a power of two)
  localparam int MAP_DIM    = 64;
  localparam int MAX_STEPS  = 128;
  localparam int ANGLE_BITS = 12;

  localparam int MAP_BITS   = $clog2(MAP_DIM);
  localparam int ADDR_W     = 2 * MAP_BITS;
  localparam int MAP_DEPTH  = MAP_DIM * MAP_DIM;
  localparam int STEP_W     = $clog2(MAX_STEPS + 1);
  localparam int QUARTER    = 1 << (ANGLE_BITS - 2);
  localparam int QTR_W      = ANGLE_BITS - 2;

  // grid cell index: player integer part plus sign and overflow
  localparam int CELL_W = 10;
  localparam logic signed [CELL_W-1:0] MAP_LIM = CELL_W'(MAP_DIM);

  // fixed point
  localparam logic [23:0] MAX24    = 24'hFFFFFF;
  localparam logic [24:0] MIN_DIST = 25'd6554;
  localparam logic [13:0] MAX_LH   = 14'd16383;
  localparam logic [40:0] FAR_DELTA = 41'h100_0000_0000;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_POS_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POS_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_ANGLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_H   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TEXTURE_W  = 3'd4;

  // item codes
  localparam logic       CMD_WRITE = 1'b0;
  localparam logic       CMD_CAST  = 1'b1;
  localparam logic [1:0] STATUS_WRITE = 2'd0;
  localparam logic [1:0] STATUS_HIT   = 2'd1;
  localparam logic [1:0] STATUS_NONE  = 2'd2;
  localparam logic [1:0] FACE_EAST  = 2'd0;
  localparam logic [1:0] FACE_WEST  = 2'd1;
  localparam logic [1:0] FACE_SOUTH = 2'd2;
  localparam logic [1:0] FACE_NORTH = 2'd3;

  // shared divider
  localparam int DIV_NUM_W = 40;
  localparam int DIV_DEN_W = 25;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
  } div_rsp_t;

  // quarter-wave sine, Q1.14, from a Q30 taylor series through x^15
  typedef logic [15:0] sine_rom_t [QUARTER];

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   t;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    for (int r = 0; r < QUARTER; r++) begin
      x    = HALF_PI_Q30 * 64'(r) / 64'(QUARTER);
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int k = 1; k <= 7; k++) begin
        term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
        if ((k % 2) == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      t[r] = 16'((64'(sum) + 64'd32768) >> 16);
    end
    return t;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// ===== design/gdr_channels.sv =====
// input and result channel interfaces of the ray caster
interface gdr_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [5:0]  cell_x;
  logic [5:0]  cell_y;
  logic        cell_wall;
  logic [11:0] cast_angle;

  modport source (output valid, command, cell_x, cell_y, cell_wall, cast_angle,
                  input ready);
  modport sink   (input valid, command, cell_x, cell_y, cell_wall, cast_angle,
                  output ready);
endinterface

interface gdr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [5:0]  hit_x;
  logic [5:0]  hit_y;
  logic [1:0]  face;
  logic [23:0] perp_distance;
  logic [13:0] line_height;
  logic [9:0]  draw_start;
  logic [9:0]  draw_end;
  logic [7:0]  texture_x;

  modport source (output valid, status, hit_x, hit_y, face, perp_distance,
                  line_height, draw_start, draw_end, texture_x, input ready);
  modport sink   (input valid, status, hit_x, hit_y, face, perp_distance,
                  line_height, draw_start, draw_end, texture_x, output ready);
endinterface

// ===== design/gdr_ram.sv =====
// generic single-port ram with registered read
module gdr_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write or read one entry a cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== design/gdr_div.sv =====
// shared restoring divider, one quotient bit a cycle
module gdr_div (
  input  logic                clk,
  input  logic                rst_n,
  input  gdr_pkg::div_req_t   req,
  output gdr_pkg::div_rsp_t   rsp
);
  import gdr_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_NUM_W-1:0] num_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_DEN_W-1:0] rem_r;
  logic [DIV_DEN_W-1:0] rem_nxt;
  logic [DIV_DEN_W:0]   rem_sh;
  logic                 q_bit;

  // trial subtract
  always_comb begin
    rem_sh = {rem_r, num_r[DIV_NUM_W-1]};
    q_bit  = (rem_sh >= {1'b0, den_r});
    if (q_bit) begin
      rem_nxt = DIV_DEN_W'(rem_sh - {1'b0, den_r});
    end else begin
      rem_nxt = rem_sh[DIV_DEN_W-1:0];
    end
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      num_r  <= '0;
      den_r  <= '0;
      rem_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        num_r  <= req.num;
        den_r  <= req.den;
        rem_r  <= '0;
        cnt_r  <= DIV_CNT_W'(DIV_NUM_W - 1);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        num_r <= {num_r[DIV_NUM_W-2:0], q_bit};
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = num_r;
endmodule

// ===== design/grid_dda_ray_caster.sv =====
// top level: wall map, sequencer, sine table, shared multiplier and divider
//
//  channel  direction  handshake            payload
//  in_if    in         valid/ready          command, cell, wall bit, ray angle
//  out_if   out        valid/ready          status, hit cell, face, distance, rows
//  cfg_*    in         cfg_wr_en            cfg_index, cfg_wr_data
//
// a cast that hits makes four passes through the shared divider plus one map
// memory read in each grid step (up to MAX_STEPS); a ray with no wall makes
// two divider passes plus one map memory read in each step.
// after reset a clearing pass writes every cell of the map; no item is
// taken meanwhile. a waiting result stalls only the sequencer's last state.
module grid_dda_ray_caster (
  input  logic                           clk,
  input  logic                           rst_n,
  gdr_in_if.sink                         in_if,
  gdr_out_if.source                      out_if,
  input  logic                           cfg_wr_en,
  input  logic [gdr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gdr_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
  import gdr_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_ANG_X, S_ANG_Y, S_ANG_C, S_DIV_X, S_DIV_XW, S_DIV_YW,
    S_SIDE_Y, S_SIDE_XL, S_SIDE_YL, S_STEP, S_CHECK, S_PERP, S_PERP_W,
    S_CORR, S_CORR_W, S_CORR_L, S_LH_W, S_TEX, S_TEX_W, S_TEX_L, S_FINISH
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [23:0] pos_x_r, pos_x_nxt, pos_y_r, pos_y_nxt;
  logic [11:0] view_r, view_nxt;
  logic [9:0]  scr_h_r, scr_h_nxt;
  logic [8:0]  tex_w_r, tex_w_nxt;

  // cast datapath
  logic [ANGLE_BITS-1:0]    ang_r, ang_nxt;
  logic signed [15:0]       dx_r, dx_nxt, dy_r, dy_nxt, c_r, c_nxt;
  logic [40:0]              ddx_r, ddx_nxt, ddy_r, ddy_nxt;
  logic [47:0]              sdx_r, sdx_nxt, sdy_r, sdy_nxt;
  logic signed [CELL_W-1:0] mx_r, mx_nxt, my_r, my_nxt;
  logic                     side_r, side_nxt;
  logic [STEP_W-1:0]        steps_r, steps_nxt;
  logic [23:0]              perp_r, perp_nxt;
  logic [13:0]              lh_r, lh_nxt;
  logic [7:0]               tx_r, tx_nxt;
  logic [1:0]               res_r, res_nxt;
  logic [ADDR_W-1:0]        clr_r, clr_nxt;

  // result register
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  o_status_r, o_status_nxt, o_face_r, o_face_nxt;
  logic [5:0]  o_hx_r, o_hx_nxt, o_hy_r, o_hy_nxt;
  logic [23:0] o_perp_r, o_perp_nxt;
  logic [13:0] o_lh_r, o_lh_nxt;
  logic [9:0]  o_ds_r, o_ds_nxt, o_de_r, o_de_nxt;
  logic [7:0]  o_tx_r, o_tx_nxt;

  // shared multiplier and sine lookup
  logic signed [25:0] mul_a_r, mul_a_nxt;
  logic signed [31:0] mul_b_r, mul_b_nxt;
  logic signed [57:0] mul_p_r;
  logic [15:0]        rom_q_r;
  logic               sin_one_r, sin_neg_r;
  logic [ANGLE_BITS-1:0] ang_sel;
  logic [QTR_W-1:0]   rom_r_idx, rom_idx;
  logic [15:0]        sine_mag;
  logic signed [15:0] sine_val;

  // memory and divider hookup
  logic              ram_we, ram_wdata, ram_rdata;
  logic [ADDR_W-1:0] ram_addr;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  // temporaries
  logic [15:0]              abs_dx, abs_dy, abs_d;
  logic [16:0]              fsel_x, fsel_y;
  logic signed [CELL_W-1:0] mx_step, my_step;
  logic                     step_x, out_map;
  logic signed [27:0]       num_s;
  logic [26:0]              anum;
  logic [24:0]              corr;
  logic [15:0]              frac;
  logic [8:0]               txr, tx_full;
  logic [9:0]               half;
  logic [12:0]              lhh;
  logic [13:0]              de_sum;
  logic [1:0]               face_c;

  gdr_ram #(.WIDTH(1), .DEPTH(MAP_DEPTH)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  gdr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // angle for the sine lookup of each state
  always_comb begin
    case (state_r)
      S_ANG_X: ang_sel = ang_r + ANGLE_BITS'(QUARTER);
      S_ANG_C: ang_sel = ang_r - ANGLE_BITS'(view_r) + ANGLE_BITS'(QUARTER);
      default: ang_sel = ang_r;
    endcase
    rom_r_idx = ang_sel[QTR_W-1:0];
    rom_idx   = ang_sel[QTR_W] ? QTR_W'(0 - rom_r_idx) : rom_r_idx;
    sine_mag  = sin_one_r ? 16'd16384 : rom_q_r;
    sine_val  = sin_neg_r ? -$signed(sine_mag) : $signed(sine_mag);
  end

  // sine table read and multiplier, one register each
  always_ff @(posedge clk) begin
    rom_q_r   <= SINE_ROM[rom_idx];
    sin_one_r <= ang_sel[QTR_W] && (rom_r_idx == '0);
    sin_neg_r <= ang_sel[QTR_W+1];
    mul_p_r   <= mul_a_r * mul_b_r;
  end

  // shared helpers
  always_comb begin
    abs_dx = dx_r[15] ? 16'(-dx_r) : 16'(dx_r);
    abs_dy = dy_r[15] ? 16'(-dy_r) : 16'(dy_r);
    fsel_x = dx_r[15] ? {1'b0, pos_x_r[15:0]} : 17'(17'd65536 - 17'(pos_x_r[15:0]));
    fsel_y = dy_r[15] ? {1'b0, pos_y_r[15:0]} : 17'(17'd65536 - 17'(pos_y_r[15:0]));
    // next grid cell
    step_x  = (sdx_r < sdy_r);
    mx_step = mx_r;
    my_step = my_r;
    if (step_x) mx_step = dx_r[15] ? mx_r - 1'b1 : mx_r + 1'b1;
    else my_step = dy_r[15] ? my_r - 1'b1 : my_r + 1'b1;
    out_map = (mx_step < 0) || (my_step < 0) || (mx_step >= MAP_LIM) ||
              (my_step >= MAP_LIM);
    // distance numerator on the hit axis
    abs_d = side_r ? abs_dy : abs_dx;
    if (!side_r) begin
      num_s = (28'(mx_r) <<< 16) - 28'(pos_x_r) + (dx_r[15] ? 28'sd65536 : 28'sd0);
    end else begin
      num_s = (28'(my_r) <<< 16) - 28'(pos_y_r) + (dy_r[15] ? 28'sd65536 : 28'sd0);
    end
    anum = num_s[27] ? 27'(-num_s) : 27'(num_s);
    // fish-eye corrected distance, clamped
    corr = (c_r > 0) ? mul_p_r[38:14] : 25'd0;
    if (corr < MIN_DIST) corr = MIN_DIST;
    // texture column
    frac = (side_r ? pos_x_r[15:0] : pos_y_r[15:0]) + mul_p_r[29:14];
    txr  = mul_p_r[24:16];
    if (tex_w_r == '0) tx_full = '0;
    else if ((!side_r && dx_r > 0) || (side_r && dy_r[15])) tx_full = tex_w_r - txr - 1'b1;
    else tx_full = txr;
    // draw rows
    half   = scr_h_r >> 1;
    lhh    = lh_r[13:1];
    de_sum = 14'(half) + 14'(lhh);
    if (!side_r) face_c = dx_r[15] ? FACE_WEST : FACE_EAST;
    else face_c = dy_r[15] ? FACE_NORTH : FACE_SOUTH;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    pos_x_nxt = pos_x_r; pos_y_nxt = pos_y_r; view_nxt = view_r;
    scr_h_nxt = scr_h_r; tex_w_nxt = tex_w_r;
    ang_nxt = ang_r; dx_nxt = dx_r; dy_nxt = dy_r; c_nxt = c_r;
    ddx_nxt = ddx_r; ddy_nxt = ddy_r; sdx_nxt = sdx_r; sdy_nxt = sdy_r;
    mx_nxt = mx_r; my_nxt = my_r; side_nxt = side_r; steps_nxt = steps_r;
    perp_nxt = perp_r; lh_nxt = lh_r; tx_nxt = tx_r; res_nxt = res_r;
    clr_nxt = clr_r;
    out_valid_nxt = out_valid_r;
    o_status_nxt = o_status_r; o_face_nxt = o_face_r; o_hx_nxt = o_hx_r;
    o_hy_nxt = o_hy_r; o_perp_nxt = o_perp_r; o_lh_nxt = o_lh_r;
    o_ds_nxt = o_ds_r; o_de_nxt = o_de_r; o_tx_nxt = o_tx_r;
    mul_a_nxt = mul_a_r; mul_b_nxt = mul_b_r;
    ram_we = 1'b0; ram_wdata = 1'b0; ram_addr = clr_r;
    div_req = '0;

    // result taken
    if (out_if.ready) out_valid_nxt = 1'b0;

    // configuration writes
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_POS_X:      pos_x_nxt = cfg_wr_data;
        REG_POS_Y:      pos_y_nxt = cfg_wr_data;
        REG_VIEW_ANGLE: view_nxt  = cfg_wr_data[11:0];
        REG_SCREEN_H:   scr_h_nxt = cfg_wr_data[9:0];
        REG_TEXTURE_W:  tex_w_nxt = cfg_wr_data[8:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_CLEAR: begin
        ram_we  = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == ADDR_W'(MAP_DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_if.valid) begin
          if (in_if.command == CMD_WRITE) begin
            ram_addr  = (ADDR_W'(in_if.cell_y) << MAP_BITS) | ADDR_W'(in_if.cell_x);
            ram_wdata = in_if.cell_wall;
            ram_we    = (int'(in_if.cell_x) < MAP_DIM) && (int'(in_if.cell_y) < MAP_DIM);
            res_nxt   = STATUS_WRITE;
            state_nxt = S_FINISH;
          end else begin
            ang_nxt   = ANGLE_BITS'(in_if.cast_angle);
            state_nxt = S_ANG_X;
          end
        end
      end
      S_ANG_X: state_nxt = S_ANG_Y;
      S_ANG_Y: begin
        dx_nxt    = sine_val;
        state_nxt = S_ANG_C;
      end
      S_ANG_C: begin
        dy_nxt    = sine_val;
        state_nxt = S_DIV_X;
      end
      S_DIV_X: begin
        c_nxt         = sine_val;
        div_req.start = 1'b1;
        div_req.num   = DIV_NUM_W'(64'd1 << 30);
        div_req.den   = DIV_DEN_W'(abs_dx);
        state_nxt     = S_DIV_XW;
      end
      S_DIV_XW: begin
        if (div_rsp.done) begin
          ddx_nxt       = (dx_r == 0) ? FAR_DELTA : 41'(div_rsp.quot[30:0]);
          div_req.start = 1'b1;
          div_req.num   = DIV_NUM_W'(64'd1 << 30);
          div_req.den   = DIV_DEN_W'(abs_dy);
          state_nxt     = S_DIV_YW;
        end
      end
      S_DIV_YW: begin
        if (div_rsp.done) begin
          ddy_nxt   = (dy_r == 0) ? FAR_DELTA : 41'(div_rsp.quot[30:0]);
          mul_a_nxt = 26'(fsel_x);
          mul_b_nxt = 32'(ddx_r[30:0]);
          state_nxt = S_SIDE_Y;
        end
      end
      S_SIDE_Y: begin
        mul_a_nxt = 26'(fsel_y);
        mul_b_nxt = 32'(ddy_r[30:0]);
        state_nxt = S_SIDE_XL;
      end
      S_SIDE_XL: begin
        sdx_nxt   = (dx_r == 0) ? (48'(fsel_x) << 24) : 48'(mul_p_r[47:16]);
        mx_nxt    = CELL_W'(pos_x_r[23:16]);
        my_nxt    = CELL_W'(pos_y_r[23:16]);
        steps_nxt = '0;
        state_nxt = S_SIDE_YL;
      end
      S_SIDE_YL: begin
        sdy_nxt   = (dy_r == 0) ? (48'(fsel_y) << 24) : 48'(mul_p_r[47:16]);
        state_nxt = S_STEP;
      end
      S_STEP: begin
        // advance one cell and read it
        if (step_x) sdx_nxt = sdx_r + 48'(ddx_r);
        else sdy_nxt = sdy_r + 48'(ddy_r);
        mx_nxt   = mx_step;
        my_nxt   = my_step;
        side_nxt = !step_x;
        ram_addr = {my_step[MAP_BITS-1:0], mx_step[MAP_BITS-1:0]};
        if (out_map) begin
          res_nxt   = STATUS_NONE;
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (ram_rdata) begin
          state_nxt = S_PERP;
        end else begin
          steps_nxt = steps_r + 1'b1;
          if (steps_nxt == STEP_W'(MAX_STEPS)) begin
            res_nxt   = STATUS_NONE;
            state_nxt = S_FINISH;
          end else begin
            state_nxt = S_STEP;
          end
        end
      end
      S_PERP: begin
        div_req.start = 1'b1;
        div_req.num   = {anum[25:0], 14'd0};
        div_req.den   = DIV_DEN_W'(abs_d);
        state_nxt     = S_PERP_W;
      end
      S_PERP_W: begin
        if (div_rsp.done) begin
          if ((abs_d == '0) || (div_rsp.quot > DIV_NUM_W'(MAX24))) perp_nxt = MAX24;
          else perp_nxt = div_rsp.quot[23:0];
          state_nxt = S_CORR;
        end
      end
      S_CORR: begin
        mul_a_nxt = 26'(perp_r);
        mul_b_nxt = 32'(c_r);
        state_nxt = S_CORR_W;
      end
      S_CORR_W: state_nxt = S_CORR_L;
      S_CORR_L: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_NUM_W'({scr_h_r, 16'd0});
        div_req.den   = corr;
        mul_a_nxt     = 26'(perp_r);
        mul_b_nxt     = side_r ? 32'(dx_r) : 32'(dy_r);
        state_nxt     = S_LH_W;
      end
      S_LH_W: begin
        if (div_rsp.done) begin
          lh_nxt    = (div_rsp.quot > DIV_NUM_W'(MAX_LH)) ? MAX_LH : div_rsp.quot[13:0];
          state_nxt = S_TEX;
        end
      end
      S_TEX: begin
        mul_a_nxt = 26'(frac);
        mul_b_nxt = 32'(tex_w_r);
        state_nxt = S_TEX_W;
      end
      S_TEX_W: state_nxt = S_TEX_L;
      S_TEX_L: begin
        tx_nxt    = (tx_full > 9'd255) ? 8'd255 : tx_full[7:0];
        res_nxt   = STATUS_HIT;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        // load the result register once it is free
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          o_status_nxt  = res_r;
          o_hx_nxt = '0; o_hy_nxt = '0; o_face_nxt = '0; o_perp_nxt = '0;
          o_lh_nxt = '0; o_ds_nxt = '0; o_de_nxt = '0; o_tx_nxt = '0;
          if (res_r == STATUS_HIT) begin
            o_hx_nxt   = 6'(mx_r);
            o_hy_nxt   = 6'(my_r);
            o_face_nxt = face_c;
            o_perp_nxt = perp_r;
            o_lh_nxt   = lh_r;
            o_ds_nxt   = (10'(lhh) > half || lhh[12:10] != '0) ? 10'd0 : 10'(half - 10'(lhh));
            if (de_sum >= 14'(scr_h_r)) o_de_nxt = (scr_h_r == '0) ? 10'd0 : scr_h_r - 1'b1;
            else o_de_nxt = de_sum[9:0];
            o_tx_nxt   = tx_r;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      pos_x_r <= '0; pos_y_r <= '0; view_r <= '0;
      scr_h_r <= 10'd480; tex_w_r <= 9'd64;
      clr_r <= '0; out_valid_r <= 1'b0; steps_r <= '0; res_r <= STATUS_WRITE;
    end else begin
      state_r <= state_nxt;
      pos_x_r <= pos_x_nxt; pos_y_r <= pos_y_nxt; view_r <= view_nxt;
      scr_h_r <= scr_h_nxt; tex_w_r <= tex_w_nxt;
      clr_r <= clr_nxt; out_valid_r <= out_valid_nxt; steps_r <= steps_nxt;
      res_r <= res_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ang_r <= ang_nxt; dx_r <= dx_nxt; dy_r <= dy_nxt; c_r <= c_nxt;
    ddx_r <= ddx_nxt; ddy_r <= ddy_nxt; sdx_r <= sdx_nxt; sdy_r <= sdy_nxt;
    mx_r <= mx_nxt; my_r <= my_nxt; side_r <= side_nxt;
    perp_r <= perp_nxt; lh_r <= lh_nxt; tx_r <= tx_nxt;
    mul_a_r <= mul_a_nxt; mul_b_r <= mul_b_nxt;
    o_status_r <= o_status_nxt; o_face_r <= o_face_nxt; o_hx_r <= o_hx_nxt;
    o_hy_r <= o_hy_nxt; o_perp_r <= o_perp_nxt; o_lh_r <= o_lh_nxt;
    o_ds_r <= o_ds_nxt; o_de_r <= o_de_nxt; o_tx_r <= o_tx_nxt;
  end

  // channel drive
  assign in_if.ready          = (state_r == S_IDLE);
  assign out_if.valid         = out_valid_r;
  assign out_if.status        = o_status_r;
  assign out_if.hit_x         = o_hx_r;
  assign out_if.hit_y         = o_hy_r;
  assign out_if.face          = o_face_r;
  assign out_if.perp_distance = o_perp_r;
  assign out_if.line_height   = o_lh_r;
  assign out_if.draw_start    = o_ds_r;
  assign out_if.draw_end      = o_de_r;
  assign out_if.texture_x     = o_tx_r;

  // a result with no wall carries nothing else
  a_none_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.status == STATUS_NONE |->
      out_if.perp_distance == '0 && out_if.line_height == '0)
    else $error("no-wall result carries data");

  // wall rows never cross
  a_rows_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.status == STATUS_HIT |-> out_if.draw_start <= out_if.draw_end)
    else $error("draw rows out of order");

  // the divider is never restarted while it runs
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  // a new result appears only from the last sequencer state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FINISH))
    else $error("result loaded outside finish");

endmodule
